// ===== src/fbld_pkg.sv =====
// Shared constants, types and helpers of the FAT buffer LRU directory.
`default_nettype none
package fbld_pkg;

  localparam int CAPACITY     = 16;
  localparam int SECTOR_BYTES = 512;
  localparam int SECTOR_W     = 21;
  localparam int CLUSTER_W    = 28;
  localparam int COPY_W       = 2;
  localparam int CMD_W        = 2;
  localparam int LIMIT_W      = 5;
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int SEC_SHIFT    = $clog2(SECTOR_BYTES) - 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(CAPACITY);

  typedef logic [SECTOR_W-1:0]  sector_t;
  typedef logic [CLUSTER_W-1:0] cluster_t;
  typedef logic [COPY_W-1:0]    copy_t;
  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [LIMIT_W-1:0]   limit_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_FETCH  = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOOK,
    OP_TOUCH,
    OP_DROP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     hit;
    logic     evict;
  } cell_ctl_t;

  typedef struct packed {
    logic    valid;
    logic    copy;
    sector_t sector;
    logic    dirty;
  } entry_t;

  typedef struct packed {
    logic    hit;
    logic    fill_needed;
    copy_t   fill_copy;
    sector_t fill_sector;
    logic    evict_valid;
    copy_t   evict_copy;
    sector_t evict_sector;
    logic    writeback;
    logic    last;
  } result_t;

  function automatic copy_t copy_code(input logic c);
    copy_code = COPY_W'(c) + COPY_W'(1);
  endfunction

endpackage
`default_nettype wire

// ===== src/fbld_req_if.sv =====
// Request channel: command beat with key and cluster.
`default_nettype none
interface fbld_req_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  fbld_pkg::copy_t      fat_copy;
  fbld_pkg::sector_t    sector;
  fbld_pkg::cluster_t   cluster;

  modport source (output valid, output cmd, output fat_copy, output sector,
                  output cluster, input ready);
  modport sink   (input valid, input cmd, input fat_copy, input sector,
                  input cluster, output ready);
endinterface
`default_nettype wire

// ===== src/fbld_rsp_if.sv =====
// Result channel: one beat per touched key or evicted entry.
`default_nettype none
interface fbld_rsp_if;
  logic              valid;
  logic              ready;
  logic              hit;
  logic              fill_needed;
  fbld_pkg::copy_t   fill_copy;
  fbld_pkg::sector_t fill_sector;
  logic              evict_valid;
  fbld_pkg::copy_t   evict_copy;
  fbld_pkg::sector_t evict_sector;
  logic              writeback;
  logic              last;

  modport source (output valid, output hit, output fill_needed, output fill_copy,
                  output fill_sector, output evict_valid, output evict_copy,
                  output evict_sector, output writeback, output last, input ready);
  modport sink   (input valid, input hit, input fill_needed, input fill_copy,
                  input fill_sector, input evict_valid, input evict_copy,
                  input evict_sector, input writeback, input last, output ready);
endinterface
`default_nettype wire

// ===== src/fat_buffer_lru_directory.sv =====
// Top level: FAT sector buffer directory with LRU replacement.
// Usage:
//   req carries cmd, fat_copy, sector and cluster; a beat is taken when valid
//   and ready are both high. rsp returns one beat per touched key or evicted
//   entry; last marks the final beat of a command. cfg_we/cfg_wdata set the
//   entry limit; they must be written only while the block is idle, which the
//   block itself does not enforce.
// Sequence: a command is taken only in idle. fetch: one result, registered
//   in S_APPLY after the lookup compare in S_LOOK. update: two results, for
//   copy 0 and then copy 1. flush: one result per held entry, none when empty.
//   Each fetch or update step compares the key, then shifts the cell row.
// Reset: all entries empty, limit 16, no result pending.
// Stall: a result waits in the output register while rsp.ready is low; the
//   directory holds its state until the register drains, and req.ready stays
//   low until the command is done.
`default_nettype none
module fat_buffer_lru_directory (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire fbld_pkg::limit_t      cfg_wdata,
  fbld_req_if.sink                   req,
  fbld_rsp_if.source                 rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_APPLY,
    S_FLUSH
  } state_t;

  state_t              state;
  fbld_pkg::limit_t    limit;
  fbld_pkg::count_t    count;
  logic                cur_copy;
  fbld_pkg::sector_t   cur_sector;
  logic                cur_mark;
  logic                cur_final;
  fbld_pkg::result_t   res;
  logic                res_valid;

  fbld_pkg::cell_ctl_t ctl;
  fbld_pkg::count_t    eff_limit;
  fbld_pkg::entry_t    victim;
  logic                hit;
  logic                evict;
  logic                out_free;
  logic                res_load;

  always_comb begin
    if (limit == '0) begin
      eff_limit = fbld_pkg::CNT_W'(1);
    end else if (limit > fbld_pkg::LIMIT_W'(fbld_pkg::CAPACITY)) begin
      eff_limit = fbld_pkg::CNT_W'(fbld_pkg::CAPACITY);
    end else begin
      eff_limit = fbld_pkg::CNT_W'(limit);
    end
  end

  assign evict    = count >= eff_limit;
  assign out_free = ~res_valid | rsp.ready;
  assign res_load = out_free &&
                    ((state == S_APPLY) || (state == S_FLUSH && count != '0));
  assign req.ready = (state == S_IDLE);

  always_comb begin
    ctl.hit   = hit;
    ctl.evict = evict;
    ctl.op    = fbld_pkg::OP_NOP;
    unique case (state)
      S_LOOK:  ctl.op = fbld_pkg::OP_LOOK;
      S_APPLY: ctl.op = out_free ? fbld_pkg::OP_TOUCH : fbld_pkg::OP_NOP;
      S_FLUSH: ctl.op = (out_free && count != '0) ? fbld_pkg::OP_DROP : fbld_pkg::OP_NOP;
      default: ctl.op = fbld_pkg::OP_NOP;
    endcase
  end

  fbld_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .key_copy   (cur_copy),
    .key_sector (cur_sector),
    .key_dirty  (cur_mark),
    .hit        (hit),
    .victim     (victim)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      limit     <= fbld_pkg::LIMIT_RESET;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            case (req.cmd)
              fbld_pkg::CMD_FETCH: begin
                cur_copy   <= req.fat_copy[1];
                cur_sector <= req.sector;
                cur_mark   <= 1'b0;
                cur_final  <= 1'b1;
                state      <= S_LOOK;
              end
              fbld_pkg::CMD_UPDATE: begin
                cur_copy   <= 1'b0;
                cur_sector <= fbld_pkg::SECTOR_W'(req.cluster >> fbld_pkg::SEC_SHIFT);
                cur_mark   <= 1'b1;
                cur_final  <= 1'b0;
                state      <= S_LOOK;
              end
              fbld_pkg::CMD_FLUSH: begin
                state <= S_FLUSH;
              end
              default: begin
              end
            endcase
          end
        end
        S_LOOK: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) begin
            res.hit          <= hit;
            res.fill_needed  <= ~hit;
            res.fill_copy    <= fbld_pkg::copy_code(cur_copy);
            res.fill_sector  <= cur_sector;
            res.evict_valid  <= ~hit & evict;
            res.evict_copy   <= (~hit & evict) ? fbld_pkg::copy_code(victim.copy) : '0;
            res.evict_sector <= (~hit & evict) ? victim.sector : '0;
            res.writeback    <= ~hit & evict & victim.dirty;
            res.last         <= cur_final;
            if (!hit && !evict) begin
              count <= count + fbld_pkg::CNT_W'(1);
            end
            if (cur_final) begin
              state <= S_IDLE;
            end else begin
              cur_copy  <= 1'b1;
              cur_final <= 1'b1;
              state     <= S_LOOK;
            end
          end
        end
        S_FLUSH: begin
          if (count == '0) begin
            state <= S_IDLE;
          end else if (out_free) begin
            res.hit          <= 1'b0;
            res.fill_needed  <= 1'b0;
            res.fill_copy    <= '0;
            res.fill_sector  <= '0;
            res.evict_valid  <= 1'b1;
            res.evict_copy   <= fbld_pkg::copy_code(victim.copy);
            res.evict_sector <= victim.sector;
            res.writeback    <= victim.dirty;
            res.last         <= (count == fbld_pkg::CNT_W'(1));
            count            <= count - fbld_pkg::CNT_W'(1);
            if (count == fbld_pkg::CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = res_valid;
  assign rsp.hit          = res.hit;
  assign rsp.fill_needed  = res.fill_needed;
  assign rsp.fill_copy    = res.fill_copy;
  assign rsp.fill_sector  = res.fill_sector;
  assign rsp.evict_valid  = res.evict_valid;
  assign rsp.evict_copy   = res.evict_copy;
  assign rsp.evict_sector = res.evict_sector;
  assign rsp.writeback    = res.writeback;
  assign rsp.last         = res.last;

endmodule
`default_nettype wire

// ===== src/fbld_cell.sv =====
// One directory cell: holds one entry and shifts it towards the LRU end.
`default_nettype none
module fbld_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire fbld_pkg::cell_ctl_t ctl,
  input  wire logic                key_copy,
  input  wire fbld_pkg::sector_t   key_sector,
  input  wire fbld_pkg::entry_t    left,
  input  wire logic                right_valid,
  input  wire logic                stop_in,
  output fbld_pkg::entry_t         content,
  output logic                     stop_out,
  output logic                     match,
  output logic                     is_last
);

  logic valid;
  logic copy;
  fbld_pkg::sector_t sector;
  logic dirty;
  logic mark;
  logic load;

  assign is_last  = valid & ~right_valid;
  assign mark     = ctl.hit ? match : (ctl.evict & is_last);
  assign stop_out = stop_in | mark;
  assign load     = (ctl.op == fbld_pkg::OP_TOUCH) & ~stop_in;

  assign content.valid  = valid;
  assign content.copy   = copy;
  assign content.sector = sector;
  assign content.dirty  = dirty;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      unique case (ctl.op)
        fbld_pkg::OP_LOOK: begin
          match <= valid & (copy == key_copy) & (sector == key_sector);
        end
        fbld_pkg::OP_TOUCH: begin
          if (load) begin
            valid <= left.valid;
          end
          match <= 1'b0;
        end
        fbld_pkg::OP_DROP: begin
          if (is_last) begin
            valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      copy   <= left.copy;
      sector <= left.sector;
      dirty  <= left.dirty;
    end
  end

endmodule
`default_nettype wire

// ===== src/fbld_chain.sv =====
// Row of directory cells ordered from most recent to least recent.
`default_nettype none
module fbld_chain (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire fbld_pkg::cell_ctl_t ctl,
  input  wire logic                key_copy,
  input  wire fbld_pkg::sector_t   key_sector,
  input  wire logic                key_dirty,
  output logic                     hit,
  output fbld_pkg::entry_t         victim
);

  fbld_pkg::entry_t content [fbld_pkg::CAPACITY];
  fbld_pkg::entry_t left    [fbld_pkg::CAPACITY];
  logic [fbld_pkg::CAPACITY:0]   stop;
  logic [fbld_pkg::CAPACITY-1:0] match_vec;
  logic [fbld_pkg::CAPACITY-1:0] last_vec;
  logic [fbld_pkg::CAPACITY-1:0] valid_vec;
  logic [fbld_pkg::CAPACITY-1:0] right_valid;
  logic hit_dirty;

  assign stop[0] = 1'b0;

  always_comb begin
    left[0].valid  = 1'b1;
    left[0].copy   = key_copy;
    left[0].sector = key_sector;
    left[0].dirty  = key_dirty | hit_dirty;
    for (int i = 1; i < fbld_pkg::CAPACITY; i++) begin
      left[i] = content[i-1];
    end
    for (int i = 0; i < fbld_pkg::CAPACITY - 1; i++) begin
      right_valid[i] = content[i+1].valid;
    end
    right_valid[fbld_pkg::CAPACITY-1] = 1'b0;
  end

  for (genvar g = 0; g < fbld_pkg::CAPACITY; g++) begin : g_cell
    fbld_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .key_copy    (key_copy),
      .key_sector  (key_sector),
      .left        (left[g]),
      .right_valid (right_valid[g]),
      .stop_in     (stop[g]),
      .content     (content[g]),
      .stop_out    (stop[g+1]),
      .match       (match_vec[g]),
      .is_last     (last_vec[g])
    );
    assign valid_vec[g] = content[g].valid;
  end

  always_comb begin
    hit_dirty = 1'b0;
    victim    = '0;
    for (int i = 0; i < fbld_pkg::CAPACITY; i++) begin
      hit_dirty = hit_dirty | (match_vec[i] & content[i].dirty);
      if (last_vec[i]) begin
        victim = victim | content[i];
      end
    end
  end

  assign hit = |match_vec;

`ifndef SYNTHESIS
  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("more than one cell matches the key");
  a_one_tail: assert property (@(posedge clk) disable iff (rst)
    $onehot0(last_vec))
    else $error("more than one least recent cell");
  a_packed: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + fbld_pkg::CAPACITY'(1))) == '0)
    else $error("valid cells are not packed at the most recent end");
  a_match_valid: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == fbld_pkg::OP_LOOK) |=> ((match_vec & ~valid_vec) == '0))
    else $error("match raised on an empty cell");
`endif

endmodule
`default_nettype wire
